// File: rtl/core/led_bit_plane_shift_driver_unit_defines.svh
// assertion macros used by the port-level checker of the led shift driver
`ifndef LED_BIT_PLANE_SHIFT_DRIVER_UNIT_DEFINES_SVH
`define LED_BIT_PLANE_SHIFT_DRIVER_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define LBPSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbpsd check failed");

// next-cycle implication, held off during reset
`define LBPSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbpsd check failed");

`endif

// File: rtl/core/lbpsd_pkg.sv
// shared types, constants and microcode table of the led shift driver
package lbpsd_pkg;

    // default grid shape
    localparam int GRID_ROWS_DEF = 10;
    localparam int GRID_COLS_DEF = 4;
    localparam int NUM_COLORS    = 3;

    // field and counter widths, and the low bit of the mask field
    localparam int PAIR_W   = 3;
    localparam int GRP_W    = 4;
    localparam int STEP_W   = 3;
    localparam int MASK_LSB = 16;

    localparam logic [9:0] BASE_PERIOD_RST = 10'd10;

    // command codes
    localparam logic [1:0] CMD_PIXEL  = 2'd0;
    localparam logic [1:0] CMD_GAMMA  = 2'd1;
    localparam logic [1:0] CMD_RENDER = 2'd2;

    typedef logic [STEP_W-1:0] step_t;

    // microprogram step addresses
    localparam step_t STEP_IDLE   = 3'd0;
    localparam step_t STEP_GATHER = 3'd1;
    localparam step_t STEP_DRAINA = 3'd2;
    localparam step_t STEP_DRAINB = 3'd3;
    localparam step_t STEP_EMITM  = 3'd4;
    localparam step_t STEP_EMITG  = 3'd5;

    // jump conditions
    typedef enum logic [1:0] {
        J_NONE  = 2'd0,
        J_CMD   = 2'd1,
        J_SLOT  = 2'd2,
        J_GROUP = 2'd3
    } jump_t;

    // one control word
    typedef struct packed {
        logic  accept;
        logic  issue_rd;
        logic  emit_mask;
        logic  emit_grp;
        jump_t jump;
        step_t target;
        logic  end_step;
    } ctrl_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic render_go;
        logic slot_last;
        logic grp_last;
        logic out_busy;
    } status_t;

    // microcode table
    function automatic ctrl_t ucode(step_t s);
        ctrl_t c;
        c = '{accept: 1'b0, issue_rd: 1'b0, emit_mask: 1'b0, emit_grp: 1'b0,
              jump: J_NONE, target: STEP_IDLE, end_step: 1'b0};
        case (s)
            STEP_IDLE:
            begin
                c.accept = 1'b1;
                c.jump   = J_CMD;
                c.target = STEP_IDLE;
            end
            STEP_GATHER:
            begin
                c.issue_rd = 1'b1;
                c.jump     = J_SLOT;
                c.target   = STEP_GATHER;
            end
            STEP_DRAINA, STEP_DRAINB:
            begin
                c.jump = J_NONE;
            end
            STEP_EMITM:
            begin
                c.emit_mask = 1'b1;
            end
            STEP_EMITG:
            begin
                c.emit_grp = 1'b1;
                c.jump     = J_GROUP;
                c.target   = STEP_GATHER;
                c.end_step = 1'b1;
            end
            default:
            begin
                c.end_step = 1'b1;
            end
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/lbpsd_ifs.sv
// command and output word channel interfaces

// command channel
interface lbpsd_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [3:0] pixel_row;
    logic [1:0] pixel_col;
    logic [1:0] color_channel;
    logic [7:0] pixel_value;
    logic [7:0] gamma_index;
    logic [7:0] gamma_value;
    logic [2:0] plane;

    modport source (output valid, command, pixel_row, pixel_col, color_channel,
                    pixel_value, gamma_index, gamma_value, plane, input ready);
    modport sink (input valid, command, pixel_row, pixel_col, color_channel,
                  pixel_value, gamma_index, gamma_value, plane, output ready);
endinterface

// shift word channel
interface lbpsd_word_if;
    logic        valid;
    logic        ready;
    logic [23:0] shift_word;
    logic [16:0] hold_time;
    logic        last_word;

    modport source (output valid, shift_word, hold_time, last_word, input ready);
    modport sink (input valid, shift_word, hold_time, last_word, output ready);
endinterface

// File: rtl/core/lbpsd_seq.sv
// microcode sequencer: step counter, control table and jump logic
module lbpsd_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  lbpsd_pkg::status_t status,
    output lbpsd_pkg::ctrl_t   ctrl
);
    import lbpsd_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  stall;
    logic  taken;

    // control word of the current step
    assign ctrl = ucode(step_reg);

    // hold on an emit step while the output register holds a word not yet taken
    assign stall = (ctrl.emit_mask || ctrl.emit_grp) && status.out_busy;

    // jump condition
    always_comb
    begin
        case (ctrl.jump)
            J_NONE:  taken = 1'b0;
            J_CMD:   taken = !status.render_go;
            J_SLOT:  taken = !status.slot_last;
            J_GROUP: taken = !status.grp_last;
            default: taken = 1'b0;
        endcase
    end

    // next step
    always_comb
    begin
        if (stall)
            step_next = step_reg;
        else if (taken)
            step_next = ctrl.target;
        else if (ctrl.end_step)
            step_next = STEP_IDLE;
        else
            step_next = step_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_IDLE;
        else
            step_reg <= step_next;
    end

endmodule

// File: rtl/core/lbpsd_dp.sv
// datapath: pixel and gamma stores, gather pipeline, mask and output register
module lbpsd_dp #(
    parameter int GRID_ROWS = lbpsd_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = lbpsd_pkg::GRID_COLS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               config_we,
    input  logic [9:0]         config_data,
    input  lbpsd_pkg::ctrl_t   ctrl,
    output lbpsd_pkg::status_t status,
    lbpsd_cmd_if.sink          cmd_bus,
    lbpsd_word_if.source       word_bus
);
    import lbpsd_pkg::*;

    localparam int PIX_DEPTH = GRID_ROWS * GRID_COLS * NUM_COLORS;
    localparam int PIX_AW    = $clog2(PIX_DEPTH);
    localparam int PAIRS     = (GRID_ROWS + 1) / 2;
    localparam int GROUPS    = PAIRS * NUM_COLORS;

    // stores
    logic [7:0] pix_mem [PIX_DEPTH];
    logic [7:0] gam_mem [256];
    logic [PIX_DEPTH-1:0] pix_valid_reg;

    logic [9:0] base_period_reg;
    logic [2:0] plane_reg;

    // render counters
    logic [2:0]        slot_reg;
    logic [2:0]        slot_next;
    logic [PAIR_W-1:0] pair_reg;
    logic [PAIR_W-1:0] pair_next;
    logic [1:0]        color_reg;
    logic [1:0]        color_next;
    logic [GRP_W-1:0]  grp_reg;
    logic [GRP_W-1:0]  grp_next;
    logic [7:0]        mask_reg;
    logic [7:0]        mask_next;

    // gather pipeline
    logic       s1_vld_reg;
    logic [2:0] s1_slot_reg;
    logic       s1_inr_reg;
    logic       s1_pv_reg;
    logic [7:0] pix_rd_reg;
    logic       s2_vld_reg;
    logic [2:0] s2_slot_reg;
    logic       s2_inr_reg;
    logic [7:0] gam_rd_reg;

    // output register
    logic        out_vld_reg;
    logic [23:0] out_word_reg;
    logic [16:0] out_hold_reg;
    logic        out_last_reg;

    logic              cmd_fire;
    logic              pix_we;
    logic              gam_we;
    logic              render_start;
    logic [7:0]        wr_lin;
    logic [PIX_AW-1:0] wr_addr;
    logic [3:0]        rd_row;
    logic              rd_inr;
    logic [7:0]        rd_lin;
    logic [PIX_AW-1:0] rd_addr;
    logic [7:0]        raw;
    logic              out_busy;
    logic              mask_fire;
    logic              grp_fire;
    logic              grp_last;

    // command decode
    assign cmd_bus.ready = ctrl.accept;
    assign cmd_fire      = cmd_bus.valid && ctrl.accept;
    assign pix_we        = cmd_fire && (cmd_bus.command == CMD_PIXEL)
                           && (cmd_bus.pixel_row < 4'(GRID_ROWS))
                           && ({1'b0, cmd_bus.pixel_col} < 3'(GRID_COLS))
                           && (cmd_bus.color_channel < 2'(NUM_COLORS));
    assign gam_we        = cmd_fire && (cmd_bus.command == CMD_GAMMA);
    assign render_start  = cmd_fire && (cmd_bus.command == CMD_RENDER);

    // linear pixel addresses
    assign wr_lin  = (8'(cmd_bus.pixel_row) * 8'(GRID_COLS) + 8'(cmd_bus.pixel_col))
                     * 8'(NUM_COLORS) + 8'(cmd_bus.color_channel);
    assign wr_addr = wr_lin[PIX_AW-1:0];

    // slot selects row of the pair (bit 2) and column (bits 1:0)
    assign rd_row  = {pair_reg, 1'b0} + {3'b000, slot_reg[2]};
    assign rd_inr  = (rd_row < 4'(GRID_ROWS)) && ({1'b0, slot_reg[1:0]} < 3'(GRID_COLS));
    assign rd_lin  = (8'(rd_row) * 8'(GRID_COLS) + 8'(slot_reg[1:0]))
                     * 8'(NUM_COLORS) + 8'(color_reg);
    assign rd_addr = rd_inr ? rd_lin[PIX_AW-1:0] : '0;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_period_reg <= BASE_PERIOD_RST;
        else if (config_we)
            base_period_reg <= config_data;
    end

    // pixel valid bits, an unwritten pixel reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_valid_reg <= '0;
        else if (pix_we)
            pix_valid_reg[wr_addr] <= 1'b1;
    end

    // pixel memory
    always_ff @(posedge clk)
    begin
        if (pix_we)
            pix_mem[wr_addr] <= cmd_bus.pixel_value;
        pix_rd_reg <= pix_mem[rd_addr];
    end

    // gamma memory, looked up with the raw pixel value
    assign raw = s1_pv_reg ? pix_rd_reg : 8'd0;

    always_ff @(posedge clk)
    begin
        if (gam_we)
            gam_mem[cmd_bus.gamma_index] <= cmd_bus.gamma_value;
        gam_rd_reg <= gam_mem[raw];
    end

    // pipeline tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= ctrl.issue_rd;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_slot_reg <= slot_reg;
        s1_inr_reg  <= rd_inr;
        s1_pv_reg   <= pix_valid_reg[rd_addr];
        s2_slot_reg <= s1_slot_reg;
        s2_inr_reg  <= s1_inr_reg;
    end

    // emit handshake
    assign out_busy  = out_vld_reg && !word_bus.ready;
    assign mask_fire = ctrl.emit_mask && !out_busy;
    assign grp_fire  = ctrl.emit_grp && !out_busy;
    assign grp_last  = (grp_reg == GRP_W'(GROUPS - 1));

    // counters and mask
    always_comb
    begin
        slot_next  = slot_reg;
        pair_next  = pair_reg;
        color_next = color_reg;
        grp_next   = grp_reg;
        mask_next  = mask_reg;
        if (ctrl.issue_rd)
            slot_next = slot_reg + 3'd1;
        if (s2_vld_reg && s2_inr_reg && gam_rd_reg[plane_reg])
            mask_next[s2_slot_reg] = 1'b1;
        if (grp_fire)
        begin
            mask_next = '0;
            grp_next  = grp_reg + GRP_W'(1);
            if (color_reg == 2'(NUM_COLORS - 1))
            begin
                color_next = '0;
                pair_next  = pair_reg + PAIR_W'(1);
            end
            else
                color_next = color_reg + 2'd1;
        end
        if (render_start)
        begin
            slot_next  = '0;
            pair_next  = '0;
            color_next = '0;
            grp_next   = '0;
            mask_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            pair_reg  <= '0;
            color_reg <= '0;
            grp_reg   <= '0;
            mask_reg  <= '0;
        end
        else
        begin
            slot_reg  <= slot_next;
            pair_reg  <= pair_next;
            color_reg <= color_next;
            grp_reg   <= grp_next;
            mask_reg  <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (render_start)
            plane_reg <= cmd_bus.plane;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (mask_fire || grp_fire)
            out_vld_reg <= 1'b1;
        else if (word_bus.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (mask_fire)
        begin
            out_word_reg <= {mask_reg, 16'h0000};
            out_hold_reg <= '0;
            out_last_reg <= 1'b0;
        end
        else if (grp_fire)
        begin
            out_word_reg <= {mask_reg, 16'(16'h0001 << grp_reg)};
            out_hold_reg <= grp_last ? (17'(base_period_reg) << plane_reg) : 17'd0;
            out_last_reg <= grp_last;
        end
    end

    assign word_bus.valid      = out_vld_reg;
    assign word_bus.shift_word = out_word_reg;
    assign word_bus.hold_time  = out_hold_reg;
    assign word_bus.last_word  = out_last_reg;

    // status to the sequencer
    assign status.render_go = render_start;
    assign status.slot_last = (slot_reg == 3'd7);
    assign status.grp_last  = grp_last;
    assign status.out_busy  = out_busy;

endmodule

// File: rtl/core/led_bit_plane_shift_driver_unit.sv
// top level of the bit-plane led shift driver
//
// Commands arrive on cmd_bus: a pixel write, a gamma table write or a bit
// plane render. Writes produce no words. A render emits two 24-bit words
// per row pair and colour on word_bus: the column mask in bits 23:16, then
// the same mask with the group-select bit set. The final word carries
// hold_time = base_period << plane and last_word. Each group of eight
// pixels goes through a microcoded loop: eight reads of the pixel memory,
// each followed by a registered gamma lookup, two drain steps and two emit
// steps. The pixel memory has a single read port. The first word is
// registered at the first emit step, after the reads and drain steps.
// cmd_bus.ready is high only while no render is in progress.
// A stalled receiver holds the word register; the sequencer waits on its
// emit step and resumes when the word is taken.
// Reset clears every pixel to zero and sets base_period to 10; the gamma
// table must be written before it is used.
module led_bit_plane_shift_driver_unit #(
    parameter int GRID_ROWS = lbpsd_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = lbpsd_pkg::GRID_COLS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         config_we,
    input  logic [9:0]   config_data,
    lbpsd_cmd_if.sink    cmd_bus,
    lbpsd_word_if.source word_bus
);
    import lbpsd_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    // microcode sequencer
    lbpsd_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // datapath
    lbpsd_dp #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .config_we   (config_we),
        .config_data (config_data),
        .ctrl        (ctrl),
        .status      (status),
        .cmd_bus     (cmd_bus),
        .word_bus    (word_bus)
    );

endmodule

// File: rtl/core/lbpsd_checker.sv
// port-level checks of the led shift driver and their bind
`include "led_bit_plane_shift_driver_unit_defines.svh"

module lbpsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_ready,
    input logic        word_valid,
    input logic        word_ready,
    input logic [23:0] shift_word,
    input logic [16:0] hold_time,
    input logic        last_word
);

    // a stalled word holds its payload
    `LBPSD_ASSERT_NXT(a_stall_hold, clk, rst_n, word_valid && !word_ready, word_valid && $stable(shift_word) && $stable(hold_time) && $stable(last_word))

    // hold time only rides on the last word
    `LBPSD_ASSERT_IMP(a_hold_last, clk, rst_n, word_valid && !last_word, hold_time == 17'd0)

    // no command is taken in the middle of a render
    `LBPSD_ASSERT_IMP(a_busy_render, clk, rst_n, word_valid && !last_word, !cmd_ready)

    // at most one group select, and the last word always has one
    `LBPSD_ASSERT_IMP(a_group_sel, clk, rst_n, word_valid, $onehot0(shift_word[15:0]) && (!last_word || (shift_word[15:0] != 16'h0000)))

endmodule

bind led_bit_plane_shift_driver_unit lbpsd_checker u_lbpsd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_ready  (cmd_bus.ready),
    .word_valid (word_bus.valid),
    .word_ready (word_bus.ready),
    .shift_word (word_bus.shift_word),
    .hold_time  (word_bus.hold_time),
    .last_word  (word_bus.last_word)
);

// File: bench/led_bit_plane_shift_driver_unit_tb.sv
// self-checking bench for the led bit-plane shift driver: directed and random command streams against a scoreboard
module led_bit_plane_shift_driver_unit_tb;

    import lbpsd_pkg::*;

    localparam int PIXEL_DEPTH    = GRID_ROWS_DEF * GRID_COLS_DEF * NUM_COLORS;
    localparam int ROW_PAIRS      = (GRID_ROWS_DEF + 1) / 2;
    localparam int NIBBLE         = 4;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_ITEMS    = 37;
    localparam int PRINT_LIMIT    = 50;

    // codes the block has no name for
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] CH_NONE    = 2'd3;

    // one command word
    typedef struct packed {
        logic [1:0] command;
        logic [3:0] pixel_row;
        logic [1:0] pixel_col;
        logic [1:0] color_channel;
        logic [7:0] pixel_value;
        logic [7:0] gamma_index;
        logic [7:0] gamma_value;
        logic [2:0] plane;
    } bcm_cmd_t;

    // one shift word
    typedef struct packed {
        logic [23:0] shift_word;
        logic [16:0] hold_time;
        logic        last_word;
    } bcm_word_t;

    // scoreboard: mirrors the pixel and gamma stores and queues predicted words
    class plane_scoreboard;
        logic [7:0]  pixel_mem [PIXEL_DEPTH];
        logic [7:0]  gamma_mirror [256];
        logic [9:0]  base_period;
        bcm_word_t   expected_words [$];
        int          errors;

        function new();
            foreach (pixel_mem[i])
                pixel_mem[i] = 8'd0;
            foreach (gamma_mirror[i])
                gamma_mirror[i] = 8'd0;
            base_period = BASE_PERIOD_RST;
            errors      = 0;
        endfunction

        task report_mismatch(string what, logic [23:0] got, logic [23:0] want);
            if (errors < PRINT_LIMIT)
                $display("MISMATCH at %0t: %s got 0x%06h want 0x%06h", $realtime, what, got,
                         want);
            errors++;
        endtask

        // all 30 words of one bit plane
        function void predict_render(logic [2:0] plane);
            logic [7:0]  mask;
            logic [23:0] word;
            bcm_word_t   w;
            int          row;
            for (int pair = 0; pair < ROW_PAIRS; pair++)
            begin
                for (int colour = 0; colour < NUM_COLORS; colour++)
                begin
                    mask = 8'd0;
                    for (int col = 0; col < GRID_COLS_DEF; col++)
                    begin
                        for (int half = 0; half < 2; half++)
                        begin
                            row = 2 * pair + half;
                            // a missing odd row leaves its nibble clear
                            if (row < GRID_ROWS_DEF)
                                mask[col + NIBBLE * half] = gamma_mirror[pixel_mem[
                                    (row * GRID_COLS_DEF + col) * NUM_COLORS + colour]][plane];
                        end
                    end
                    word = 24'(mask) << MASK_LSB;
                    w    = '{shift_word: word, hold_time: 17'd0, last_word: 1'b0};
                    expected_words.push_back(w);
                    word[pair * NUM_COLORS + colour] = 1'b1;
                    w.shift_word = word;
                    if (pair == ROW_PAIRS - 1 && colour == NUM_COLORS - 1)
                    begin
                        w.hold_time = 17'(base_period) << plane;
                        w.last_word = 1'b1;
                    end
                    expected_words.push_back(w);
                end
            end
        endfunction

        // accepted command word
        function void note_command(bcm_cmd_t c);
            case (c.command)
                CMD_PIXEL:
                begin
                    if (c.pixel_row < GRID_ROWS_DEF && c.pixel_col < GRID_COLS_DEF &&
                        c.color_channel != CH_NONE)
                        pixel_mem[(int'(c.pixel_row) * GRID_COLS_DEF + int'(c.pixel_col)) *
                                  NUM_COLORS + int'(c.color_channel)] = c.pixel_value;
                end
                CMD_GAMMA:
                    gamma_mirror[c.gamma_index] = c.gamma_value;
                CMD_RENDER:
                    predict_render(c.plane);
                default:
                    ;
            endcase
        endfunction

        // accepted shift word against the oldest prediction
        task check_word(bcm_word_t got);
            bcm_word_t want;
            if (expected_words.size() == 0)
            begin
                report_mismatch("word with nothing expected", got.shift_word, 24'd0);
                return;
            end
            want = expected_words.pop_front();
            if (got.shift_word !== want.shift_word)
                report_mismatch("shift_word", got.shift_word, want.shift_word);
            if (got.hold_time !== want.hold_time)
                report_mismatch("hold_time", 24'(got.hold_time), 24'(want.hold_time));
            if (got.last_word !== want.last_word)
                report_mismatch("last_word", 24'(got.last_word), 24'(want.last_word));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       config_we;
    logic [9:0] config_data;

    lbpsd_cmd_if  cmd_bus ();
    lbpsd_word_if word_bus ();

    led_bit_plane_shift_driver_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .config_we   (config_we),
        .config_data (config_data),
        .cmd_bus     (cmd_bus),
        .word_bus    (word_bus)
    );

    plane_scoreboard sb = new();

    // stimulus-side view of what has been sent, so no unloaded gamma entry is read
    logic [7:0] pixel_shadow [PIXEL_DEPTH];
    bit         gamma_loaded [256];
    int         loaded_list [$];
    bit         sender_gaps_on;
    int         idle_cycles;
    int         phase_base [PHASE_COUNT];

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // acceptance monitor and watchdog
    always @(posedge clk)
    begin : monitor
        bcm_cmd_t  c;
        bcm_word_t w;
        bit        moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                c.command       = cmd_bus.command;
                c.pixel_row     = cmd_bus.pixel_row;
                c.pixel_col     = cmd_bus.pixel_col;
                c.color_channel = cmd_bus.color_channel;
                c.pixel_value   = cmd_bus.pixel_value;
                c.gamma_index   = cmd_bus.gamma_index;
                c.gamma_value   = cmd_bus.gamma_value;
                c.plane         = cmd_bus.plane;
                sb.note_command(c);
                moved = 1'b1;
            end
            if (word_bus.valid && word_bus.ready)
            begin
                w.shift_word = word_bus.shift_word;
                w.hold_time  = word_bus.hold_time;
                w.last_word  = word_bus.last_word;
                sb.check_word(w);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // word receiver: runs of ready broken by stalls, mostly short
    initial
    begin : receiver
        int run;
        int stall;
        word_bus.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            run = ($urandom_range(99) < 15) ? $urandom_range(50, 200) : $urandom_range(1, 6);
            word_bus.ready <= 1'b1;
            repeat (run) @(negedge clk);
            stall = ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            word_bus.ready <= 1'b0;
            repeat (stall) @(negedge clk);
        end
    end

    function automatic int pick_gap();
        int r;
        if (!sender_gaps_on)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bcm_cmd_t random_fields();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(bcm_cmd_t)-1:0];
    endfunction

    // present one command word; called and returns at a falling edge
    task automatic drive_command(bcm_cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_bus.valid         <= 1'b1;
        cmd_bus.command       <= c.command;
        cmd_bus.pixel_row     <= c.pixel_row;
        cmd_bus.pixel_col     <= c.pixel_col;
        cmd_bus.color_channel <= c.color_channel;
        cmd_bus.pixel_value   <= c.pixel_value;
        cmd_bus.gamma_index   <= c.gamma_index;
        cmd_bus.gamma_value   <= c.gamma_value;
        cmd_bus.plane         <= c.plane;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_pixel(int row, int col, int ch, int value);
        bcm_cmd_t c;
        c               = random_fields();
        c.command       = CMD_PIXEL;
        c.pixel_row     = 4'(row);
        c.pixel_col     = 2'(col);
        c.color_channel = 2'(ch);
        c.pixel_value   = 8'(value);
        if (row < GRID_ROWS_DEF && col < GRID_COLS_DEF && ch < NUM_COLORS)
            pixel_shadow[(row * GRID_COLS_DEF + col) * NUM_COLORS + ch] = 8'(value);
        drive_command(c);
    endtask

    task automatic send_gamma(int index, int value);
        bcm_cmd_t c;
        c             = random_fields();
        c.command     = CMD_GAMMA;
        c.gamma_index = 8'(index);
        c.gamma_value = 8'(value);
        if (!gamma_loaded[index])
        begin
            gamma_loaded[index] = 1'b1;
            loaded_list.push_back(index);
        end
        drive_command(c);
    endtask

    // load any gamma entry a stored pixel would read, then render
    task automatic send_render(int plane);
        bcm_cmd_t c;
        for (int i = 0; i < PIXEL_DEPTH; i++)
        begin
            if (!gamma_loaded[pixel_shadow[i]])
                send_gamma(pixel_shadow[i], $urandom_range(255));
        end
        c         = random_fields();
        c.command = CMD_RENDER;
        c.plane   = 3'(plane);
        drive_command(c);
    endtask

    task automatic send_unused();
        bcm_cmd_t c;
        c         = random_fields();
        c.command = CMD_UNUSED;
        drive_command(c);
    endtask

    // wait for every predicted word, then let trailing writes settle
    task automatic wait_drained();
        while (sb.expected_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // base period may only change with the block idle
    task automatic set_base_period(logic [9:0] value);
        cmd_bus.valid <= 1'b0;
        wait_drained();
        config_we   <= 1'b1;
        config_data <= value;
        sb.base_period = value;
        @(negedge clk);
        config_we <= 1'b0;
    endtask

    // pixel writes (mostly in range, on loaded gamma values) with gamma writes, renders and unused commands
    task automatic random_commands(int count);
        int r;
        int row;
        int ch;
        int value;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 50)
            begin
                if ($urandom_range(9) == 0)
                begin
                    row = $urandom_range(15);
                    ch  = $urandom_range(3);
                end
                else
                begin
                    row = $urandom_range(GRID_ROWS_DEF - 1);
                    ch  = $urandom_range(NUM_COLORS - 1);
                end
                if (loaded_list.size() > 0 && $urandom_range(3) != 0)
                    value = loaded_list[$urandom_range(loaded_list.size() - 1)];
                else
                    value = $urandom_range(255);
                send_pixel(row, $urandom_range(3), ch, value);
            end
            else if (r < 75)
                send_gamma($urandom_range(255), $urandom_range(255));
            else if (r < 95)
                send_render($urandom_range(7));
            else
                send_unused();
        end
    endtask

    // main sequence
    initial
    begin
        rst_n                 = 1'b0;
        config_we             = 1'b0;
        config_data           = 10'd0;
        cmd_bus.valid         = 1'b0;
        cmd_bus.command       = CMD_PIXEL;
        cmd_bus.pixel_row     = 4'd0;
        cmd_bus.pixel_col     = 2'd0;
        cmd_bus.color_channel = 2'd0;
        cmd_bus.pixel_value   = 8'd0;
        cmd_bus.gamma_index   = 8'd0;
        cmd_bus.gamma_value   = 8'd0;
        cmd_bus.plane         = 3'd0;
        idle_cycles           = 0;
        sender_gaps_on        = 1'b1;
        foreach (pixel_shadow[i])
            pixel_shadow[i] = 8'd0;
        foreach (gamma_loaded[i])
            gamma_loaded[i] = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // cleared grid at the reset base period, lowest and highest planes
        send_gamma(0, 8'hFF);
        send_render(0);
        send_render(7);

        // extreme gamma entries, pixels at three grid corners and two more pixels
        send_gamma(0, 8'h00);
        send_gamma(255, 8'hFF);
        send_gamma(8'h80, 8'h80);
        send_gamma(1, 8'h01);
        send_pixel(0, 0, 0, 255);
        send_pixel(GRID_ROWS_DEF - 1, GRID_COLS_DEF - 1, 2, 255);
        send_pixel(GRID_ROWS_DEF - 1, 0, 1, 8'h80);
        send_pixel(4, 2, 1, 1);
        send_pixel(1, 3, 0, 255);

        // writes that must be dropped: row past the grid, unused channel, unused command
        send_pixel(GRID_ROWS_DEF, 0, 0, 255);
        send_pixel(15, 3, 2, 255);
        send_pixel(2, 1, CH_NONE, 255);
        send_unused();
        send_render(7);
        send_render(0);

        // longest hold time, zero base period, smallest nonzero base period
        set_base_period(10'd1023);
        send_render(7);
        set_base_period(10'd0);
        send_render(5);
        set_base_period(10'd1);
        send_render(0);

        // random phases across base period settings
        phase_base[0] = 10'($urandom_range(2, 1022));
        phase_base[1] = 10'd1023;
        phase_base[2] = 10'd1;
        phase_base[3] = 10'd0;
        phase_base[4] = BASE_PERIOD_RST;
        phase_base[5] = 10'($urandom_range(2, 1022));
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            set_base_period(10'(phase_base[p]));
            sender_gaps_on = ($urandom_range(3) != 0);
            random_commands(PHASE_ITEMS);
            send_render($urandom_range(7));
        end

        cmd_bus.valid <= 1'b0;
        wait_drained();
        if (sb.expected_words.size() != 0)
            sb.report_mismatch("words never produced", 24'(sb.expected_words.size()), 24'd0);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
